// ===== src/tvp_pkg.sv =====
// tvp_pkg: shared constants and types for the trapezoid velocity profile block.
// No dependencies.
package tvp_pkg;
	localparam logic signed [63:0] SAT_LIM = 64'sd2305843009213693952;
	localparam logic [0:0] CMD_PLAN = 1'b0;
	localparam logic [0:0] CMD_TICK = 1'b1;
	typedef logic signed [63:0] wide_t;

	function automatic wide_t sat(input wide_t v, input wide_t lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input wide_t v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// ===== src/trapezoid_velocity_profile.sv =====
// trapezoid_velocity_profile: trapezoidal move planner and set point generator.
// A plan beat runs up to seven divides, or six plus a square root, through one shared divider;
// a tick beat runs three multiplies on a ramp, one while coasting and none with no move planned.
// One beat in flight at a time; in_ready stays low until the result beat is taken.
// Reset (arst_n, asynchronous): registers to 65536/65536/655, no move planned.
module trapezoid_velocity_profile #(
	parameter int FRACTION_BITS = 16,
	parameter int INDEX_BITS = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [30:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic signed [31:0]      origin_position,
	input  logic signed [31:0]      origin_velocity,
	input  logic signed [31:0]      target_position,
	input  logic signed [31:0]      target_velocity,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      position,
	output logic signed [31:0]      velocity,
	output logic signed [31:0]      acceleration,
	output logic [INDEX_BITS:0]     point_count,
	output logic                    last_point,
	output logic                    status
);
	import tvp_pkg::*;

	localparam logic [1:0] REG_VLIM = 2'd0;
	localparam logic [1:0] REG_ALIM = 2'd1;
	localparam logic [1:0] REG_STEP = 2'd2;
	localparam logic [INDEX_BITS:0] MAX_CNT = (INDEX_BITS+1)'(1) << INDEX_BITS;

	// sequencer states
	localparam logic [4:0] S_IDLE = 5'd0,  S_P0 = 5'd1,  S_P1 = 5'd2,  S_P2 = 5'd3;
	localparam logic [4:0] S_P3 = 5'd4,  S_P4 = 5'd5,  S_P5 = 5'd6,  S_P6 = 5'd7;
	localparam logic [4:0] S_P7 = 5'd8,  S_P8 = 5'd9,  S_P9 = 5'd10, S_P10 = 5'd11;
	localparam logic [4:0] S_T0 = 5'd12, S_T1 = 5'd13, S_T2 = 5'd14, S_T3 = 5'd15;
	localparam logic [4:0] S_T4 = 5'd16, S_T5 = 5'd17, S_OUT = 5'd18, S_P11 = 5'd19;

	logic [30:0] vlim_q, alim_q;
	logic [16:0] step_q;
	logic signed [31:0] base_pos_q, base_vel_q, peak_q, ta_q, tc_q, ad_q, cr_q;
	logic dir_q, planned_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS:0] total_q;
	logic [4:0] st_q;

	// plan scratch
	wide_t dm_q, vs_q, ve_q, vp_q, ad_w_q, cr_w_q, td_w_q, tmp_q, t_q;
	logic [63:0] vs2_q, ve2_q;
	logic neg_w_q;
	// tick scratch
	wide_t s_q, v_q, a_q, u_q;
	logic [1:0] ph_q;

	wide_t aw, vw, sw;
	assign aw = (alim_q == '0) ? 64'sd1 : wide_t'({33'd0, alim_q});
	assign vw = (vlim_q == '0) ? 64'sd1 : wide_t'({33'd0, vlim_q});
	assign sw = (step_q == '0) ? 64'sd1 : wide_t'({47'd0, step_q});

	// shared units
	logic mul_go, mul_done, div_go, div_sq, div_done;
	wide_t mul_a, mul_b, mul_y;
	logic [63:0] div_n, div_d, div_q;
	logic div_neg_q;

	tvp_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
		.clk, .arst_n, .start(mul_go), .a(mul_a), .b(mul_b), .done(mul_done), .y(mul_y)
	);
	tvp_div u_div (
		.clk, .arst_n, .start(div_go), .sqrt_mode(div_sq), .n(div_n), .d(div_d),
		.done(div_done), .q(div_q)
	);

	wide_t divs;
	assign divs = div_neg_q ? -wide_t'(div_q) : wide_t'(div_q);

	function automatic logic [63:0] mag(input wide_t v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// every squared or scaled plan term has 32-bit operands
	function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
		logic [63:0] p;
		p = x * y;
		return p;
	endfunction

	assign in_ready = (st_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlim_q <= 31'd65536;
			alim_q <= 31'd65536;
			step_q <= 17'd655;
			base_pos_q <= '0; base_vel_q <= '0; peak_q <= '0; ta_q <= '0;
			tc_q <= '0; ad_q <= '0; cr_q <= '0;
			dir_q <= 1'b0; planned_q <= 1'b0; idx_q <= '0; total_q <= '0;
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			mul_go <= 1'b0; div_go <= 1'b0; div_sq <= 1'b0;
			ph_q <= '0;
		end else begin
			mul_go <= 1'b0;
			div_go <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_VLIM: vlim_q <= cfg_data;
					REG_ALIM: alim_q <= cfg_data;
					REG_STEP: step_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						position <= '0; velocity <= '0; acceleration <= '0;
						last_point <= 1'b0; status <= 1'b0;
						if (cmd == CMD_PLAN) begin
							tmp_q <= wide_t'(target_position) - wide_t'(origin_position);
							base_pos_q <= origin_position;
							base_vel_q <= origin_velocity;
							vs_q <= wide_t'(origin_velocity);
							ve_q <= wide_t'(target_velocity);
							ph_q <= '0;
							st_q <= S_P0;
						end else if (!planned_q) begin
							status <= 1'b1;
							point_count <= total_q;
							out_valid <= 1'b1;
						end else begin
							t_q <= wide_t'(idx_q) * sw;
							ph_q <= '0;
							st_q <= S_T0;
						end
					end
				end
				// direction, squares, ad = (V^2 - vs^2)/2A
				S_P0: begin
					neg_w_q <= tmp_q[63];
					dm_q <= wide_t'(mag(tmp_q));
					if (tmp_q[63]) begin
						vs_q <= -vs_q; ve_q <= -ve_q;
					end
					vs2_q <= mul32(32'(mag(vs_q)), 32'(mag(vs_q)));
					ve2_q <= mul32(32'(mag(ve_q)), 32'(mag(ve_q)));
					vp_q <= vw;
					st_q <= S_P1;
				end
				S_P1: begin
					tmp_q <= wide_t'(mul32(vp_q[31:0], vp_q[31:0]));
					st_q <= S_P2;
				end
				S_P2: begin
					div_neg_q <= 64'(tmp_q) < vs2_q;
					div_n <= (64'(tmp_q) >= vs2_q) ? 64'(tmp_q) - vs2_q : vs2_q - 64'(tmp_q);
					div_d <= 64'(aw) << 1;
					div_sq <= 1'b0; div_go <= 1'b1;
					st_q <= S_P3;
				end
				S_P3: if (div_done) begin
					ad_w_q <= divs;
					if (ph_q == 2'd1) begin
						ph_q <= '0;
						st_q <= S_P6;
					end else begin
						div_neg_q <= 64'(tmp_q) < ve2_q;
						div_n <= (64'(tmp_q) >= ve2_q) ? 64'(tmp_q) - ve2_q : ve2_q - 64'(tmp_q);
						div_go <= 1'b1;
						st_q <= S_P4;
					end
				end
				S_P4: if (div_done) begin
					cr_w_q <= dm_q - (ad_w_q + divs);
					st_q <= S_P5;
				end
				S_P5: begin
					if (cr_w_q < 0) begin
						div_n <= mul32(32'(dm_q), 32'(aw)) + ((vs2_q + ve2_q) >> 1);
						div_sq <= 1'b1; div_go <= 1'b1;
						cr_w_q <= '0;
						st_q <= S_P11;
					end else st_q <= S_P6;
				end
				S_P11: if (div_done) begin
					vp_q <= wide_t'(div_q);
					tmp_q <= wide_t'(mul32(div_q[31:0], div_q[31:0]));
					ph_q <= 2'd1;
					st_q <= S_P2;
				end
				// ta, td and tc
				S_P6: begin
					tmp_q <= (vp_q - vs_q) <<< FRACTION_BITS;
					st_q <= S_P7;
				end
				S_P7: begin
					div_neg_q <= tmp_q[63];
					div_n <= mag(tmp_q); div_d <= 64'(aw);
					div_sq <= 1'b0; div_go <= 1'b1;
					st_q <= S_P8;
				end
				S_P8: if (div_done) begin
					if (ph_q == 2'd0) begin
						ta_q <= sat32(divs);
						tmp_q <= (vp_q - ve_q) <<< FRACTION_BITS;
						ph_q <= 2'd1;
						st_q <= S_P7;
					end else if (ph_q == 2'd1) begin
						td_w_q <= wide_t'(sat32(divs));
						tc_q <= '0;
						if (cr_w_q > 0) begin
							div_neg_q <= 1'b0;
							div_n <= 64'(cr_w_q); div_d <= 64'(vp_q);
							div_go <= 1'b1;
							ph_q <= 2'd2;
						end else st_q <= S_P9;
					end else if (ph_q == 2'd2) begin
						if ((div_q >> (31 - FRACTION_BITS)) != 0) begin
							tc_q <= 32'sh7fffffff;
							st_q <= S_P9;
						end else begin
							div_n <= 64'(cr_w_q) << FRACTION_BITS;
							div_go <= 1'b1;
							ph_q <= 2'd3;
						end
					end else begin
						tc_q <= sat32(divs);
						st_q <= S_P9;
					end
				end
				S_P9: begin
					tmp_q <= wide_t'(ta_q) + wide_t'(tc_q) + td_w_q;
					dir_q <= neg_w_q;
					peak_q <= sat32(vp_q);
					ad_q <= sat32(ad_w_q);
					cr_q <= sat32(cr_w_q);
					st_q <= S_P10;
					ph_q <= '0;
				end
				S_P10: begin
					if (ph_q == 2'd0) begin
						if (tmp_q < 0) begin
							total_q <= (INDEX_BITS+1)'(2);
							ph_q <= 2'd2;
						end else begin
							div_neg_q <= 1'b0;
							div_n <= 64'(tmp_q); div_d <= 64'(sw);
							div_go <= 1'b1;
							ph_q <= 2'd1;
						end
					end else if (ph_q == 2'd1) begin
						if (div_done) begin
							if (div_q >= 64'(MAX_CNT)) total_q <= MAX_CNT;
							else if (div_q == 0) total_q <= (INDEX_BITS+1)'(2);
							else total_q <= (INDEX_BITS+1)'(div_q) + 1'b1;
							ph_q <= 2'd2;
						end
					end else begin
						idx_q <= '0;
						planned_q <= 1'b1;
						point_count <= total_q;
						out_valid <= 1'b1;
						ph_q <= '0;
						st_q <= S_IDLE;
					end
				end
				// tick: pick segment
				S_T0: begin
					vs_q <= dir_q ? -wide_t'(base_vel_q) : wide_t'(base_vel_q);
					if (t_q <= wide_t'(ta_q)) begin
						a_q <= aw; u_q <= t_q; ph_q <= 2'd0;
						mul_a <= aw; mul_b <= t_q;
					end else if (t_q <= wide_t'(ta_q) + wide_t'(tc_q)) begin
						a_q <= '0; u_q <= t_q - wide_t'(ta_q); ph_q <= 2'd1;
						mul_a <= wide_t'(peak_q); mul_b <= t_q - wide_t'(ta_q);
					end else begin
						a_q <= -aw; u_q <= t_q - wide_t'(ta_q) - wide_t'(tc_q); ph_q <= 2'd2;
						mul_a <= aw; mul_b <= t_q - wide_t'(ta_q) - wide_t'(tc_q);
					end
					mul_go <= 1'b1;
					st_q <= S_T1;
				end
				S_T1: if (mul_done) begin
					case (ph_q)
						2'd0: begin
							v_q <= sat(vs_q + mul_y, SAT_LIM);
							mul_a <= mul_y; mul_b <= u_q;
						end
						2'd1: begin
							v_q <= wide_t'(peak_q);
							s_q <= sat(wide_t'(ad_q) + mul_y, SAT_LIM);
						end
						default: begin
							v_q <= sat(wide_t'(peak_q) - mul_y, SAT_LIM);
							mul_a <= mul_y; mul_b <= u_q;
						end
					endcase
					if (ph_q == 2'd1) st_q <= S_T5;
					else begin
						mul_go <= 1'b1;
						st_q <= S_T2;
					end
				end
				S_T2: if (mul_done) begin
					tmp_q <= mul_y / 2;
					mul_go <= 1'b1;
					if (ph_q == 2'd0) begin
						mul_a <= vs_q; mul_b <= u_q;
					end else begin
						mul_a <= wide_t'(peak_q); mul_b <= u_q;
					end
					st_q <= S_T3;
				end
				S_T3: if (mul_done) begin
					if (ph_q == 2'd0)
						s_q <= sat(mul_y + tmp_q, SAT_LIM);
					else
						s_q <= sat(sat(wide_t'(ad_q) + wide_t'(cr_q) + mul_y, SAT_LIM) - tmp_q,
							SAT_LIM);
					st_q <= S_T5;
				end
				S_T5: begin
					if (dir_q) begin
						position <= sat32(wide_t'(base_pos_q) - s_q);
						velocity <= sat32(-v_q);
						acceleration <= 32'(-a_q);
					end else begin
						position <= sat32(wide_t'(base_pos_q) + s_q);
						velocity <= sat32(v_q);
						acceleration <= 32'(a_q);
					end
					point_count <= total_q;
					if ((INDEX_BITS+1)'(idx_q) + 1'b1 >= total_q) begin
						last_point <= 1'b1;
						planned_q <= 1'b0;
					end
					idx_q <= idx_q + 1'b1;
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/tvp_mul.sv =====
// tvp_mul: multi-cycle fixed-point multiply x*y>>F on magnitudes, saturated at 2^61.
// Uses tvp_pkg. One 32x32 partial product per cycle.
module tvp_mul #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tvp_pkg::wide_t      a,
	input  tvp_pkg::wide_t      b,
	output logic                done,
	output tvp_pkg::wide_t      y
);
	import tvp_pkg::*;
	logic [63:0] ua_q, ub_q;
	logic [127:0] acc_q;
	logic [2:0] ph_q;
	logic busy_q, neg_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] sh;
	logic [63:0] r;

	always_comb begin
		pa = ph_q[1] ? ua_q[63:32] : ua_q[31:0];
		pb = ph_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp = 64'(pa) * 64'(pb);
		sh = {64'd0, pp} << (7'(ph_q[1]) * 7'd32 + 7'(ph_q[0]) * 7'd32);
		r = 64'(acc_q >> FRACTION_BITS);
		if ((acc_q >> FRACTION_BITS) > 128'(SAT_LIM)) r = 64'(SAT_LIM);
		y = neg_q ? -wide_t'(r) : wide_t'(r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			ph_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q <= '0;
				ua_q <= a[63] ? 64'(-a) : 64'(a);
				ub_q <= b[63] ? 64'(-b) : 64'(b);
				neg_q <= a[63] ^ b[63];
				acc_q <= '0;
			end else if (busy_q) begin
				acc_q <= acc_q + sh;
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd3) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== src/tvp_div.sv =====
// tvp_div: restoring unsigned divider, one quotient bit per cycle, 64-bit operands.
// Also computes floor square root in the same shift loop (sqrt mode). Uses tvp_pkg.
module tvp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sqrt_mode,
	input  logic [63:0] n,
	input  logic [63:0] d,
	output logic        done,
	output logic [63:0] q
);
	import tvp_pkg::*;
	logic [63:0] num_q, den_q, rem_q, res_q, bit_q;
	logic [6:0] cnt_q;
	logic busy_q, sq_q;
	logic [64:0] trial;
	logic [63:0] rs;

	assign rs = res_q + bit_q;
	assign trial = {rem_q[63:0], num_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sq_q <= sqrt_mode;
				num_q <= n;
				den_q <= d;
				rem_q <= '0;
				res_q <= '0;
				bit_q <= 64'h4000000000000000;
				cnt_q <= sqrt_mode ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				if (sq_q) begin
					if (num_q >= rs) begin
						num_q <= num_q - rs;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						res_q <= {res_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], num_q[63]};
						res_q <= {res_q[62:0], 1'b0};
					end
					num_q <= {num_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign q = res_q;
endmodule
